// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands, clocked and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the cycle after the antecedent
`define TVV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// consequent checked in the same cycle as the antecedent
`define TVV_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/tvv_pkg.sv
// ----------------------------------------------------------------------------
// tvv_pkg
// shared types and constants of the typed value validator
// ----------------------------------------------------------------------------
package tvv_pkg;

  typedef logic [2:0] col_type_t;

  localparam col_type_t COL_TEXT  = 3'd0;
  localparam col_type_t COL_INT   = 3'd1;
  localparam col_type_t COL_FLOAT = 3'd2;
  localparam col_type_t COL_BOOL  = 3'd3;
  localparam col_type_t COL_DATE  = 3'd4;
  localparam col_type_t COL_TIME  = 3'd5;
  localparam col_type_t COL_STAMP = 3'd6;

  // number recognizer states, reject is not stored
  typedef enum logic [3:0] {
    REC_START,
    REC_SIGN,
    REC_INT,
    REC_DOT_LEAD,
    REC_DOT,
    REC_FRAC,
    REC_EXP,
    REC_EXP_SIGN,
    REC_EXP_DIG
  } rec_state_t;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LOW_E = 8'h65;
  localparam logic [7:0] CASE_BIT = 8'h20;

  localparam logic [4:0] POS_MAX  = 5'd31;
  localparam logic [4:0] DATE_LEN = 5'd10;
  localparam logic [4:0] TIME_LEN = 5'd8;
  localparam logic [4:0] STAMP_LEN = 5'd19;

  localparam int WORD_COUNT = 8;

  // boolean words, lower case, zero padded to eight bytes
  localparam logic [7:0] BOOL_WORDS [WORD_COUNT][8] = '{
    '{8'h74, 8'h72, 8'h75, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h66, 8'h61, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00},
    '{8'h31, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h30, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h79, 8'h65, 8'h73, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h6E, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h6F, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h6F, 8'h66, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] BOOL_LENS [WORD_COUNT] = '{
    3'd4, 3'd5, 3'd1, 3'd1, 3'd3, 3'd2, 3'd2, 3'd3
  };

  // classified item as it travels from front to back
  typedef struct packed {
    logic [7:0] lc_char;
    logic       is_digit;
    logic       is_sign;
    logic       is_dot;
    logic       is_exp;
    logic       is_dash;
    logic       is_space;
    logic       is_colon;
    logic       last;
    logic       empty;
    col_type_t  ctype;
  } tvv_item_t;

endpackage

// File: hw/rtl/tvv_front.sv
// ----------------------------------------------------------------------------
// tvv_front
// classifies one input byte into the flags the recognizers need
// ----------------------------------------------------------------------------
module tvv_front (
  input  logic [7:0]         char_code,
  input  logic               last_char,
  input  logic               empty_value,
  input  tvv_pkg::col_type_t ctype,
  output tvv_pkg::tvv_item_t item
);
  import tvv_pkg::*;

  logic [7:0] lc;

  always_comb begin
    lc = char_code;
    if (char_code >= CH_UP_A && char_code <= CH_UP_Z) begin
      lc = char_code | CASE_BIT;
    end
    item.lc_char  = lc;
    item.is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    item.is_sign  = (char_code == CH_PLUS) || (char_code == CH_MINUS);
    item.is_dot   = (char_code == CH_DOT);
    item.is_exp   = (lc == CH_LOW_E);
    item.is_dash  = (char_code == CH_MINUS);
    item.is_space = (char_code == CH_SPACE);
    item.is_colon = (char_code == CH_COLON);
    item.last     = last_char;
    item.empty    = empty_value;
    item.ctype    = ctype;
  end

endmodule

// File: hw/rtl/tvv_queue.sv
// ----------------------------------------------------------------------------
// tvv_queue
// small first-in first-out buffer of classified items
// ----------------------------------------------------------------------------
module tvv_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tvv_pkg::tvv_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output tvv_pkg::tvv_item_t head_item
);
  import tvv_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tvv_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: hw/rtl/tvv_back.sv
// ----------------------------------------------------------------------------
// tvv_back
// per-value recognizers, verdict and output register
// ----------------------------------------------------------------------------
module tvv_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  tvv_pkg::tvv_item_t q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_value_valid
);
  import tvv_pkg::*;

  rec_state_t rec_r, rec_nxt;
  logic [4:0] pos_r, pos_nxt;
  logic [7:0] cand_r, cand_nxt;
  logic       fail_r, fail_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_vv_r, out_vv_nxt;

  rec_state_t int_next, float_next;
  logic       int_rej, float_rej;
  logic       date_ok, time_ok, stamp_ok;
  logic [7:0] word_hit;
  logic       bool_ok;
  rec_state_t upd_rec;
  logic [4:0] upd_pos;
  logic [7:0] upd_cand;
  logic       upd_fail;
  logic       verdict;
  logic [4:0] p;

  assign p               = pos_r;
  assign q_pop           = q_valid && (!out_valid_r || out_ready);
  assign out_valid       = out_valid_r;
  assign out_value_valid = out_vv_r;

  // integer recognizer step
  always_comb begin
    int_next = REC_INT;
    int_rej  = 1'b1;
    unique case (rec_r)
      REC_START: begin
        int_rej  = !(q_item.is_sign || q_item.is_digit);
        int_next = q_item.is_sign ? REC_SIGN : REC_INT;
      end
      REC_SIGN, REC_INT: begin
        int_rej  = !q_item.is_digit;
        int_next = REC_INT;
      end
      default: begin
        int_rej  = 1'b1;
        int_next = REC_INT;
      end
    endcase
  end

  // float recognizer step
  always_comb begin
    float_next = REC_START;
    float_rej  = 1'b1;
    unique case (rec_r)
      REC_START: begin
        float_rej = !(q_item.is_sign || q_item.is_digit || q_item.is_dot);
        float_next = q_item.is_sign  ? REC_SIGN :
                     q_item.is_digit ? REC_INT  : REC_DOT_LEAD;
      end
      REC_SIGN: begin
        float_rej  = !(q_item.is_digit || q_item.is_dot);
        float_next = q_item.is_digit ? REC_INT : REC_DOT_LEAD;
      end
      REC_INT: begin
        float_rej  = !(q_item.is_digit || q_item.is_dot || q_item.is_exp);
        float_next = q_item.is_digit ? REC_INT :
                     q_item.is_dot   ? REC_DOT : REC_EXP;
      end
      REC_DOT_LEAD: begin
        float_rej  = !q_item.is_digit;
        float_next = REC_FRAC;
      end
      REC_DOT, REC_FRAC: begin
        float_rej  = !(q_item.is_digit || q_item.is_exp);
        float_next = q_item.is_digit ? REC_FRAC : REC_EXP;
      end
      REC_EXP: begin
        float_rej  = !(q_item.is_sign || q_item.is_digit);
        float_next = q_item.is_sign ? REC_EXP_SIGN : REC_EXP_DIG;
      end
      REC_EXP_SIGN, REC_EXP_DIG: begin
        float_rej  = !q_item.is_digit;
        float_next = REC_EXP_DIG;
      end
      default: begin
        float_rej  = 1'b1;
        float_next = REC_START;
      end
    endcase
  end

  // fixed digit layouts
  always_comb begin
    date_ok = (p < DATE_LEN) &&
              ((p == 5'd4 || p == 5'd7) ? q_item.is_dash : q_item.is_digit);
    time_ok = (p < TIME_LEN) &&
              ((p == 5'd2 || p == 5'd5) ? q_item.is_colon : q_item.is_digit);
    if (p == 5'd4 || p == 5'd7) begin
      stamp_ok = q_item.is_dash;
    end else if (p == 5'd10) begin
      stamp_ok = q_item.is_space;
    end else if (p == 5'd13 || p == 5'd16) begin
      stamp_ok = q_item.is_colon;
    end else begin
      stamp_ok = q_item.is_digit && (p < STAMP_LEN);
    end
  end

  // boolean word match, one lane per word
  always_comb begin
    for (int k = 0; k < WORD_COUNT; k++) begin
      word_hit[k] = (p < {2'b00, BOOL_LENS[k]}) &&
                    (BOOL_WORDS[k][p[2:0]] == q_item.lc_char);
    end
  end

  always_comb begin
    upd_rec  = rec_r;
    upd_fail = fail_r;
    upd_cand = cand_r;
    upd_pos  = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
    unique case (q_item.ctype)
      COL_INT: begin
        if (int_rej) upd_fail = 1'b1;
        else upd_rec = int_next;
      end
      COL_FLOAT: begin
        if (float_rej) upd_fail = 1'b1;
        else upd_rec = float_next;
      end
      COL_BOOL:  upd_cand = cand_r & word_hit;
      COL_DATE:  upd_fail = fail_r | !date_ok;
      COL_TIME:  upd_fail = fail_r | !time_ok;
      COL_STAMP: upd_fail = fail_r | !stamp_ok;
      default:   upd_fail = fail_r;
    endcase
  end

  always_comb begin
    bool_ok = 1'b0;
    for (int k = 0; k < WORD_COUNT; k++) begin
      bool_ok = bool_ok | (upd_cand[k] && ({2'b00, BOOL_LENS[k]} == upd_pos));
    end
    unique case (q_item.ctype)
      COL_INT:   verdict = !upd_fail && (upd_rec == REC_INT);
      COL_FLOAT: verdict = !upd_fail &&
                           (upd_rec inside {REC_INT, REC_DOT, REC_FRAC, REC_EXP_DIG});
      COL_BOOL:  verdict = bool_ok;
      COL_DATE:  verdict = !upd_fail && (upd_pos == DATE_LEN);
      COL_TIME:  verdict = !upd_fail && (upd_pos == TIME_LEN);
      COL_STAMP: verdict = !upd_fail && (upd_pos == STAMP_LEN);
      default:   verdict = 1'b1;
    endcase
  end

  always_comb begin
    rec_nxt       = rec_r;
    pos_nxt       = pos_r;
    cand_nxt      = cand_r;
    fail_nxt      = fail_r;
    out_vv_nxt    = out_vv_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (q_pop) begin
      if (q_item.empty || q_item.last) begin
        // value complete: show verdict and restart
        rec_nxt       = REC_START;
        pos_nxt       = '0;
        cand_nxt      = '1;
        fail_nxt      = 1'b0;
        out_valid_nxt = 1'b1;
        if (q_item.empty) begin
          out_vv_nxt = (q_item.ctype == COL_TEXT) || (q_item.ctype > COL_STAMP);
        end else begin
          out_vv_nxt = verdict;
        end
      end else begin
        rec_nxt  = upd_rec;
        pos_nxt  = upd_pos;
        cand_nxt = upd_cand;
        fail_nxt = upd_fail;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r       <= REC_START;
      pos_r       <= '0;
      cand_r      <= '1;
      fail_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rec_r       <= rec_nxt;
      pos_r       <= pos_nxt;
      cand_r      <= cand_nxt;
      fail_r      <= fail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_vv_r <= out_vv_nxt;
  end

endmodule

// File: hw/rtl/typed_value_validator.sv
// ----------------------------------------------------------------------------
// typed_value_validator
// checks a text value, one byte per item, against the configured column type
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       input      in_valid / in_ready   in_char_code, in_last_char, in_empty_value
//  out      output     out_valid / out_ready out_value_valid
//  cfg      input      cfg_wr_en             cfg_wr_data (column type)
//
// one item per cycle sustained unless a result stalls; the back recognizer takes
// one queued item a cycle. a verdict goes through the queue, then the output reg.
// in_ready drops only when QUEUE_DEPTH items wait behind a stalled result.
// synchronous active-low reset clears the queue, recognizer state and column type.
// QUEUE_DEPTH range is 2 to 16.
module typed_value_validator #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       in_last_char,
  input  logic       in_empty_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_value_valid,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data
);
  import tvv_pkg::*;

  col_type_t ctype_r, ctype_nxt;
  tvv_item_t front_item;
  tvv_item_t head_item;
  logic      q_full;
  logic      q_push;
  logic      q_pop;
  logic      head_valid;

  assign ctype_nxt = cfg_wr_en ? cfg_wr_data : ctype_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctype_r <= COL_TEXT;
    end else begin
      ctype_r <= ctype_nxt;
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  tvv_front u_front (
    .char_code   (in_char_code),
    .last_char   (in_last_char),
    .empty_value (in_empty_value),
    .ctype       (ctype_r),
    .item        (front_item)
  );

  tvv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (front_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  tvv_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (head_valid),
    .q_item          (head_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value_valid (out_value_valid)
  );

endmodule

// File: hw/rtl/tvv_checker.sv
// ----------------------------------------------------------------------------
// tvv_checker
// port-level assertions on the typed value validator, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tvv_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_last_char,
  input logic in_empty_value,
  input logic out_valid,
  input logic out_ready,
  input logic out_value_valid
);

  // values ended at the input but not yet delivered
  logic [7:0] pending_r, pending_nxt;
  logic       end_in, res_out;

  assign end_in  = in_valid && in_ready && (in_last_char || in_empty_value);
  assign res_out = out_valid && out_ready;

  always_comb begin
    pending_nxt = pending_r;
    if (end_in && !res_out) pending_nxt = pending_r + 1'b1;
    if (!end_in && res_out) pending_nxt = pending_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  `TVV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_value_valid), "stalled result changed")
  `TVV_ASSERT_SAME(a_ready_after_reset, clk, rst_n, $past(!rst_n),
    in_ready, "input not ready after reset")
  `TVV_ASSERT_SAME(a_no_invented, clk, rst_n, out_valid,
    pending_r != 8'd0, "result with no completed value")
  `TVV_ASSERT_SAME(a_full_only_stalled, clk, rst_n, !in_ready,
    out_valid, "input blocked while output is free")

endmodule

bind typed_value_validator tvv_checker u_tvv_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_last_char    (in_last_char),
  .in_empty_value  (in_empty_value),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_value_valid (out_value_valid)
);
